// ===== hdl/active_note_guard_table_macros.svh =====
// Assertion macros used by the active note guard table controller.
// Depends on nothing; the using module must provide clk and arst_n.
`ifndef ACTIVE_NOTE_GUARD_TABLE_MACROS_SVH
`define ACTIVE_NOTE_GUARD_TABLE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ANGT_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ANGT_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/angt_pkg.sv =====
// Package for the active note guard table: function codes, defaults and
// the command and status bundles between controller and datapath. No dependencies.
`default_nettype none
package angt_pkg;

	localparam int DEF_TRACKS = 8;
	localparam int DEF_SLOTS = 8;
	localparam int MAX_RECORDS = 64;
	localparam int REC_CNT_W = 7;
	localparam int IN_DATA_W = 88;
	localparam int OUT_DATA_W = 80;

	typedef enum logic [2:0] {
		FN_NOTE_ON  = 3'd0,
		FN_NOTE_OFF = 3'd1,
		FN_QUERY    = 3'd2,
		FN_PANIC    = 3'd3,
		FN_CLEAR    = 3'd4
	} func_e_t;

	typedef struct packed {
		logic accept;
		logic init;
		logic read;
		logic eval;
		logic push;
		logic finish;
	} angt_cmd_t;

	typedef struct packed {
		logic need_scan;
		logic rec_hit;
		logic pend_valid;
		logic scan_end;
		logic out_free;
	} angt_sts_t;

endpackage
`default_nettype wire

// ===== hdl/angt_ctrl.sv =====
// Controller state machine of the active note guard table.
// Depends on angt_pkg and active_note_guard_table_macros.svh.
`default_nettype none
`include "active_note_guard_table_macros.svh"
module angt_ctrl import angt_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s_tvalid,
	output logic           s_tready,
	input  wire angt_sts_t sts,
	output angt_cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_READ,
		ST_EVAL,
		ST_PUSH,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   rdy_q;

	assign s_tready = rdy_q;

	always_comb begin
		cmd        = '0;
		cmd.accept = s_tvalid && rdy_q;
		cmd.init   = (state_q == ST_DECIDE) && sts.need_scan;
		cmd.read   = (state_q == ST_READ);
		cmd.eval   = (state_q == ST_EVAL);
		cmd.push   = (state_q == ST_PUSH) && sts.out_free;
		cmd.finish = (state_q == ST_FINISH) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rdy_q   <= 1'b1;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid && rdy_q) begin
						state_q <= ST_DECIDE;
						rdy_q   <= 1'b0;
					end
				end
				ST_DECIDE: begin
					state_q <= sts.need_scan ? ST_READ : ST_FINISH;
				end
				ST_READ: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					priority if (sts.rec_hit && sts.pend_valid) begin
						state_q <= ST_PUSH;
					end else if (sts.scan_end) begin
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_READ;
					end
				end
				ST_PUSH: begin
					if (sts.out_free) begin
						state_q <= sts.scan_end ? ST_FINISH : ST_READ;
					end
				end
				ST_FINISH: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
						rdy_q   <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					rdy_q   <= 1'b1;
				end
			endcase
		end
	end

	`ANGT_ASSERT_IMP(a_push_has_pending, state_q == ST_PUSH, sts.pend_valid, "push without pending record")
	`ANGT_ASSERT_NEXT(a_finish_returns, (state_q == ST_FINISH) && sts.out_free, (state_q == ST_IDLE) && s_tready, "finish did not return to idle")
	`ANGT_ASSERT_NEXT(a_accept_blocks, s_tvalid && s_tready, (state_q == ST_DECIDE) && !s_tready, "accept did not close the input")

endmodule
`default_nettype wire

// ===== hdl/angt_dp.sv =====
// Datapath of the active note guard table: slot memory, active bits,
// scan counters, counters and output register. Depends on angt_pkg.
`default_nettype none
module angt_dp import angt_pkg::*; #(
	parameter int TRACKS = DEF_TRACKS,
	parameter int SLOTS_PER_TRACK = DEF_SLOTS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	input  wire logic [2:0]            s_tuser,
	input  wire angt_cmd_t             cmd,
	output angt_sts_t                  sts,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,
	output logic                       m_tuser,
	output logic                       m_tlast
);

	localparam int Total = TRACKS * SLOTS_PER_TRACK;
	localparam int AW = (Total > 1) ? $clog2(Total) : 1;
	localparam int TW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
	localparam int SW = (SLOTS_PER_TRACK > 1) ? $clog2(SLOTS_PER_TRACK) : 1;
	localparam logic [AW-1:0] LastAll = AW'(Total - 1);
	localparam logic [AW-1:0] LastTrk = AW'(SLOTS_PER_TRACK - 1);
	localparam logic [SW-1:0] LastSub = SW'(SLOTS_PER_TRACK - 1);
	localparam logic [REC_CNT_W-1:0] MaxRec = REC_CNT_W'(MAX_RECORDS);

	typedef struct packed {
		logic [6:0]  note;
		logic [1:0]  dest;
		logic [31:0] occ;
		logic [31:0] gen;
	} slot_rec_t;

	slot_rec_t mem [Total];
	slot_rec_t rd_q;

	func_e_t     func_q;
	logic [7:0]  track_q;
	logic [7:0]  note_q;
	logic [31:0] occ_q;
	logic [31:0] gen_q;
	logic [1:0]  dest_q;
	logic        stopw_q;

	logic [Total-1:0]     act_q;
	logic [AW-1:0]        addr_q;
	logic [AW-1:0]        cnt_q;
	logic [SW-1:0]        sub_q;
	logic [TW-1:0]        trk_q;
	logic                 hit_q;
	logic [AW-1:0]        hit_addr_q;
	logic                 free_q;
	logic [AW-1:0]        free_addr_q;
	logic [REC_CNT_W-1:0] n_q;
	logic                 pend_valid_q;
	logic [2:0]           pend_trk_q;
	logic [6:0]           pend_note_q;
	logic [1:0]           pend_dest_q;
	logic [31:0]          orph_q;
	logic [31:0]          dupc_q;

	logic                 args_ok;
	logic                 id_ok;
	logic                 need_scan;
	logic [AW-1:0]        base;
	logic                 cur_act;
	logic                 id_m;
	logic                 note_m;
	logic                 rec_hit;
	logic                 take;
	logic                 advance;
	logic                 wr_en;
	logic                 off_clr;
	logic                 out_free;
	logic                 m_valid_q;
	logic                 o_ok;
	logic                 o_has;
	logic [2:0]           o_trk;
	logic [6:0]           o_note;
	logic [1:0]           o_dest;
	logic                 o_stop;
	logic                 o_last;
	logic [31:0]          orph_nx;
	logic [31:0]          dupc_nx;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic                 out_user_q;
	logic                 out_last_q;

	assign args_ok = (track_q < 8'(TRACKS)) && !note_q[7];
	assign id_ok   = (occ_q != 32'd0) && (gen_q != 32'd0);
	assign base    = AW'(int'(track_q[TW-1:0]) * SLOTS_PER_TRACK);
	assign cur_act = act_q[addr_q];
	assign id_m    = (rd_q.occ == occ_q) && (rd_q.gen == gen_q);
	assign note_m  = (rd_q.note == note_q[6:0]);
	assign rec_hit = (func_q == FN_PANIC) && cur_act && (n_q < MaxRec);
	assign take    = (cmd.eval && rec_hit && !pend_valid_q) || cmd.push;
	assign advance = (cmd.eval && !(rec_hit && pend_valid_q)) || cmd.push;
	assign wr_en   = cmd.finish && (func_q == FN_NOTE_ON) && need_scan && !hit_q && free_q;
	assign off_clr = cmd.finish && (func_q == FN_NOTE_OFF) && need_scan && hit_q;
	assign out_free = !m_valid_q || m_tready;

	always_comb begin
		unique case (func_q)
			FN_NOTE_ON, FN_NOTE_OFF: need_scan = args_ok && id_ok;
			FN_QUERY:                need_scan = args_ok;
			FN_PANIC:                need_scan = 1'b1;
			default:                 need_scan = 1'b0;
		endcase
	end

	always_comb begin
		sts            = '0;
		sts.need_scan  = need_scan;
		sts.rec_hit    = rec_hit;
		sts.pend_valid = pend_valid_q;
		sts.scan_end   = (cnt_q == ((func_q == FN_PANIC) ? LastAll : LastTrk));
		sts.out_free   = out_free;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q  <= func_e_t'(s_tuser);
			track_q <= s_tdata[7:0];
			note_q  <= s_tdata[15:8];
			occ_q   <= s_tdata[47:16];
			gen_q   <= s_tdata[79:48];
			dest_q  <= s_tdata[81:80];
			stopw_q <= s_tdata[82];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[free_addr_q] <= '{note: note_q[6:0], dest: dest_q, occ: occ_q, gen: gen_q};
		end
		if (cmd.read) begin
			rd_q <= mem[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= '0;
		end else if (cmd.finish && (func_q == FN_CLEAR)) begin
			act_q <= '0;
		end else begin
			if (take) begin
				act_q[addr_q] <= 1'b0;
			end
			if (wr_en) begin
				act_q[free_addr_q] <= 1'b1;
			end
			if (off_clr) begin
				act_q[hit_addr_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q       <= '0;
			cnt_q        <= '0;
			sub_q        <= '0;
			trk_q        <= '0;
			hit_q        <= 1'b0;
			hit_addr_q   <= '0;
			free_q       <= 1'b0;
			free_addr_q  <= '0;
			n_q          <= '0;
			pend_valid_q <= 1'b0;
		end else if (cmd.init) begin
			addr_q       <= (func_q == FN_PANIC) ? '0 : base;
			cnt_q        <= '0;
			sub_q        <= '0;
			trk_q        <= '0;
			hit_q        <= 1'b0;
			free_q       <= 1'b0;
			n_q          <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			if (cmd.eval) begin
				unique case (func_q)
					FN_NOTE_ON: begin
						if (cur_act && id_m) begin
							hit_q <= 1'b1;
						end
						if (!cur_act && !free_q) begin
							free_q      <= 1'b1;
							free_addr_q <= addr_q;
						end
					end
					FN_NOTE_OFF: begin
						if (cur_act && note_m && id_m && !hit_q) begin
							hit_q      <= 1'b1;
							hit_addr_q <= addr_q;
						end
					end
					FN_QUERY: begin
						if (cur_act && note_m) begin
							hit_q <= 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			if (take) begin
				pend_valid_q <= 1'b1;
				n_q          <= n_q + REC_CNT_W'(1);
			end
			if (advance) begin
				addr_q <= addr_q + AW'(1);
				cnt_q  <= cnt_q + AW'(1);
				if (sub_q == LastSub) begin
					sub_q <= '0;
					trk_q <= trk_q + TW'(1);
				end else begin
					sub_q <= sub_q + SW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pend_trk_q  <= 3'(trk_q);
			pend_note_q <= rd_q.note;
			pend_dest_q <= rd_q.dest;
		end
	end

	always_comb begin
		orph_nx = orph_q;
		dupc_nx = dupc_q;
		o_ok    = 1'b0;
		o_has   = 1'b0;
		o_trk   = '0;
		o_note  = '0;
		o_dest  = '0;
		o_stop  = 1'b0;
		o_last  = 1'b1;
		if (cmd.push) begin
			o_ok   = 1'b1;
			o_has  = 1'b1;
			o_trk  = pend_trk_q;
			o_note = pend_note_q;
			o_dest = pend_dest_q;
			o_last = 1'b0;
		end else begin
			unique case (func_q)
				FN_NOTE_ON: begin
					o_ok = need_scan && (hit_q || free_q);
					if (need_scan && hit_q) begin
						dupc_nx = dupc_q + 32'd1;
					end
				end
				FN_NOTE_OFF: begin
					o_ok = need_scan && hit_q;
					if (need_scan && !hit_q) begin
						orph_nx = orph_q + 32'd1;
					end
				end
				FN_QUERY: begin
					o_ok = need_scan && hit_q;
				end
				FN_PANIC: begin
					o_ok   = 1'b1;
					o_stop = stopw_q;
					if (pend_valid_q) begin
						o_has  = 1'b1;
						o_trk  = pend_trk_q;
						o_note = pend_note_q;
						o_dest = pend_dest_q;
					end
				end
				FN_CLEAR: begin
					o_ok    = 1'b1;
					orph_nx = '0;
					dupc_nx = '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orph_q <= '0;
			dupc_q <= '0;
		end else if (cmd.finish) begin
			orph_q <= orph_nx;
			dupc_q <= dupc_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.push || cmd.finish) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push || cmd.finish) begin
			out_data_q <= {2'b00, dupc_nx, orph_nx, o_stop, o_dest, o_note, o_trk, o_ok};
			out_user_q <= o_has;
			out_last_q <= o_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

endmodule
`default_nettype wire

// ===== hdl/active_note_guard_table.sv =====
// Top level of the active note guard table.
// Depends on angt_pkg, angt_ctrl and angt_dp.
// One request is taken at a time. A note-on, note-off or query reads the
// SLOTS_PER_TRACK slots of its track through the single-port slot memory,
// each slot in a read state and then an evaluate state; refused requests,
// clear and undefined codes go straight from the decide state to finish.
// A panic reads all TRACKS * SLOTS_PER_TRACK slots the same way, with a push
// state for each flushed record after the first; push and finish wait while
// the output register is full and m_tready is low.
// Results wait in an output register, so the next request is taken while
// the last result is still pending.
`default_nettype none
module active_note_guard_table import angt_pkg::*; #(
	parameter int TRACKS = DEF_TRACKS,
	parameter int SLOTS_PER_TRACK = DEF_SLOTS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// track[7:0], note[15:8], occ_id[47:16], generation[79:48],
	// dest_mask[81:80], stop_wanted[82]
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// func[2:0]
	input  wire logic [2:0]            s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// ok[0], rec_track[3:1], rec_note[10:4], rec_dest[12:11], stop_request[13],
	// orphan_count[45:14], duplicate_count[77:46]
	output logic [OUT_DATA_W-1:0]      m_tdata,
	// has_record[0]
	output logic                       m_tuser,
	output logic                       m_tlast
);

	angt_cmd_t cmd;
	angt_sts_t sts;

	angt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	angt_dp #(
		.TRACKS          (TRACKS),
		.SLOTS_PER_TRACK (SLOTS_PER_TRACK)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

// ===== tb/active_note_guard_table_test.sv =====
// Self-checking testbench for the active note guard table.
// Depends on angt_pkg and active_note_guard_table; predicts every result of
// each request and compares it with the block's output stream.
`default_nettype none
module active_note_guard_table_test import angt_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TRACKS = 8;
	localparam int SLOTS = 8;
	localparam int TOTAL = TRACKS * SLOTS;

	typedef struct packed {
		logic        ok;
		logic        has_record;
		logic [2:0]  rec_track;
		logic [6:0]  rec_note;
		logic [1:0]  rec_dest;
		logic        stop_request;
		logic        last;
		logic [31:0] orphan_count;
		logic [31:0] duplicate_count;
	} note_status_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic [2:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic m_tuser;
	logic m_tlast;

	active_note_guard_table #(.TRACKS(TRACKS), .SLOTS_PER_TRACK(SLOTS)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic        held_active [TOTAL];
	logic [6:0]  held_note [TOTAL];
	logic [1:0]  held_dest [TOTAL];
	logic [31:0] held_occ [TOTAL];
	logic [31:0] held_gen [TOTAL];
	logic [31:0] orphan_total;
	logic [31:0] duplicate_total;
	note_status_t pending_status[$];
	int errors = 0;
	int send_idle = 0;
	int recv_idle = 0;

	task automatic clear_table();
		for (int s = 0; s < TOTAL; s++) begin
			held_active[s] = 1'b0;
			held_note[s] = '0;
			held_dest[s] = '0;
			held_occ[s] = '0;
			held_gen[s] = '0;
		end
		orphan_total = '0;
		duplicate_total = '0;
	endtask

	function automatic note_status_t plain_status(logic ok);
		note_status_t r;
		r = '0;
		r.ok = ok;
		r.last = 1'b1;
		r.orphan_count = orphan_total;
		r.duplicate_count = duplicate_total;
		return r;
	endfunction

	task automatic predict_request(logic [2:0] func, logic [7:0] track, logic [7:0] note,
			logic [31:0] occ, logic [31:0] gen, logic [1:0] dmask, logic stopw);
		logic args_ok;
		logic ok;
		logic done;
		int base;
		int n;
		note_status_t r;
		args_ok = (track < TRACKS) && (note < 128);
		base = args_ok ? track * SLOTS : 0;
		ok = 1'b0;
		done = 1'b0;
		n = 0;
		if ((func == FN_NOTE_ON || func == FN_NOTE_OFF) && (!args_ok || occ == 0 || gen == 0)) begin
			pending_status.push_back(plain_status(1'b0));
			return;
		end
		case (func)
			FN_NOTE_ON: begin
				for (int i = 0; i < SLOTS && !done; i++)
					if (held_active[base+i] && held_occ[base+i] == occ && held_gen[base+i] == gen) begin
						duplicate_total++;
						ok = 1'b1;
						done = 1'b1;
					end
				for (int i = 0; i < SLOTS && !done; i++)
					if (!held_active[base+i]) begin
						held_active[base+i] = 1'b1;
						held_note[base+i] = note[6:0];
						held_dest[base+i] = dmask;
						held_occ[base+i] = occ;
						held_gen[base+i] = gen;
						ok = 1'b1;
						done = 1'b1;
					end
			end
			FN_NOTE_OFF: begin
				for (int i = 0; i < SLOTS && !done; i++)
					if (held_active[base+i] && held_note[base+i] == note[6:0]
							&& held_occ[base+i] == occ && held_gen[base+i] == gen) begin
						held_active[base+i] = 1'b0;
						ok = 1'b1;
						done = 1'b1;
					end
				if (!ok)
					orphan_total++;
			end
			FN_QUERY: begin
				if (args_ok)
					for (int i = 0; i < SLOTS; i++)
						if (held_active[base+i] && held_note[base+i] == note[6:0])
							ok = 1'b1;
			end
			FN_PANIC: begin
				for (int s = 0; s < TOTAL; s++)
					if (held_active[s] && n < MAX_RECORDS) begin
						r = plain_status(1'b1);
						r.last = 1'b0;
						r.has_record = 1'b1;
						r.rec_track = 3'(s / SLOTS);
						r.rec_note = held_note[s];
						r.rec_dest = held_dest[s];
						held_active[s] = 1'b0;
						pending_status.push_back(r);
						n++;
					end
				if (n == 0) begin
					r = plain_status(1'b1);
					r.stop_request = stopw;
					pending_status.push_back(r);
				end else begin
					pending_status[$].stop_request = stopw;
					pending_status[$].last = 1'b1;
				end
				return;
			end
			FN_CLEAR: begin
				clear_table();
				ok = 1'b1;
			end
			default: ok = 1'b0;
		endcase
		pending_status.push_back(plain_status(ok));
	endtask

	task automatic send_request(logic [2:0] func, logic [7:0] track, logic [7:0] note,
			logic [31:0] occ, logic [31:0] gen, logic [1:0] dmask, logic stopw);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tuser <= func;
		s_tdata <= {5'b0, stopw, dmask, gen, occ, note, track};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_request(func, track, note, occ, gen, dmask, stopw);
		@(negedge clk);
	endtask

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_idle);

	always @(posedge clk) begin
		note_status_t got;
		note_status_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.ok = m_tdata[0];
			got.has_record = m_tuser;
			got.rec_track = m_tdata[3:1];
			got.rec_note = m_tdata[10:4];
			got.rec_dest = m_tdata[12:11];
			got.stop_request = m_tdata[13];
			got.last = m_tlast;
			got.orphan_count = m_tdata[45:14];
			got.duplicate_count = m_tdata[77:46];
			if (pending_status.size() == 0) begin
				$error("result with no expectation: %h", got);
				errors++;
			end else begin
				want = pending_status.pop_front();
				if (got.ok !== want.ok) begin
					$error("ok: expected %h, got %h", want.ok, got.ok); errors++;
				end
				if (got.has_record !== want.has_record) begin
					$error("has_record: expected %h, got %h", want.has_record, got.has_record);
					errors++;
				end
				if (got.rec_track !== want.rec_track) begin
					$error("rec_track: expected %h, got %h", want.rec_track, got.rec_track);
					errors++;
				end
				if (got.rec_note !== want.rec_note) begin
					$error("rec_note: expected %h, got %h", want.rec_note, got.rec_note);
					errors++;
				end
				if (got.rec_dest !== want.rec_dest) begin
					$error("rec_dest: expected %h, got %h", want.rec_dest, got.rec_dest);
					errors++;
				end
				if (got.stop_request !== want.stop_request) begin
					$error("stop_request: expected %h, got %h", want.stop_request,
						got.stop_request);
					errors++;
				end
				if (got.last !== want.last) begin
					$error("last: expected %h, got %h", want.last, got.last); errors++;
				end
				if (got.orphan_count !== want.orphan_count) begin
					$error("orphan_count: expected %h, got %h", want.orphan_count,
						got.orphan_count);
					errors++;
				end
				if (got.duplicate_count !== want.duplicate_count) begin
					$error("duplicate_count: expected %h, got %h", want.duplicate_count,
						got.duplicate_count);
					errors++;
				end
			end
		end
	end

	task automatic test_directed();
		send_request(FN_PANIC, 0, 0, 0, 0, 0, 1'b1);
		send_request(FN_NOTE_ON, 0, 0, 1, 1, 2'd0, 0);
		send_request(FN_NOTE_ON, 7, 127, 32'hFFFFFFFF, 32'hFFFFFFFF, 2'd3, 0);
		send_request(FN_NOTE_ON, 7, 5, 32'hFFFFFFFF, 32'hFFFFFFFF, 2'd1, 0);
		send_request(FN_NOTE_ON, 8, 1, 1, 1, 0, 0);
		send_request(FN_NOTE_ON, 255, 255, 1, 1, 0, 0);
		send_request(FN_NOTE_ON, 0, 128, 1, 1, 0, 0);
		send_request(FN_NOTE_ON, 0, 1, 0, 1, 0, 0);
		send_request(FN_NOTE_ON, 0, 1, 1, 0, 0, 0);
		for (int i = 0; i < 9; i++)
			send_request(FN_NOTE_ON, 3, 8'(40 + i), 32'(100 + i), 7, 2'(i), 0);
		send_request(FN_QUERY, 3, 41, 0, 0, 0, 0);
		send_request(FN_QUERY, 3, 99, 0, 0, 0, 0);
		send_request(FN_QUERY, 9, 41, 0, 0, 0, 0);
		send_request(FN_NOTE_OFF, 3, 41, 101, 7, 0, 0);
		send_request(FN_NOTE_OFF, 3, 41, 101, 7, 0, 0);
		send_request(FN_NOTE_OFF, 0, 1, 0, 0, 0, 0);
		send_request(3'd5, 0, 0, 0, 0, 0, 0);
		send_request(3'd7, 0, 0, 0, 0, 0, 0);
		send_request(FN_PANIC, 0, 0, 0, 0, 0, 1'b0);
		send_request(FN_CLEAR, 0, 0, 0, 0, 0, 0);
	endtask

	task automatic test_full_panic();
		for (int t = 0; t < TRACKS; t++)
			for (int i = 0; i < SLOTS; i++)
				send_request(FN_NOTE_ON, 8'(t), 8'($urandom_range(127)),
					$urandom_range(1, 9999), $urandom, 2'($urandom_range(3)), 0);
		send_request(FN_PANIC, 0, 0, 0, 0, 0, 1'b1);
	endtask

	task automatic test_random(int count);
		logic [2:0] func;
		logic [7:0] track;
		logic [7:0] note;
		logic [31:0] occ;
		logic [31:0] gen;
		int pick;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(99);
			track = 8'($urandom_range(TRACKS - 1));
			note = 8'($urandom_range(127));
			occ = $urandom_range(1, 6);
			gen = $urandom_range(1, 2);
			if (pick < 40)
				func = FN_NOTE_ON;
			else if (pick < 70)
				func = FN_NOTE_OFF;
			else if (pick < 82)
				func = FN_QUERY;
			else if (pick < 88)
				func = FN_PANIC;
			else if (pick < 90)
				func = FN_CLEAR;
			else begin
				func = 3'($urandom);
				track = 8'($urandom);
				note = 8'($urandom);
				occ = $urandom;
				gen = $urandom;
			end
			if (func == FN_NOTE_OFF && $urandom_range(3) != 0) begin
				for (int s = 0; s < TOTAL; s++)
					if (held_active[s] && $urandom_range(3) == 0) begin
						track = 8'(s / SLOTS);
						note = {1'b0, held_note[s]};
						occ = held_occ[s];
						gen = held_gen[s];
					end
			end
			send_request(func, track, note, occ, gen, 2'($urandom), 1'($urandom));
		end
	endtask

	initial begin
		clear_table();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		send_idle = 36;
		recv_idle = 50;
		test_directed();
		test_full_panic();
		test_random(40);
		send_idle = 50;
		recv_idle = 36;
		test_random(40);
		send_idle = 0;
		recv_idle = 0;
		test_random(30);
		s_tvalid <= 1'b0;
		while (pending_status.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0 && pending_status.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#5ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire
